// File: rtl/spsk_pkg.sv
// ----------------------------------------------------------------------------
// spsk_pkg - shared types and constants for the stepper phase sequencer
// Field widths, register indexes, reset values, sequencer states and the
// request/response bundle of the shared divider.
// ----------------------------------------------------------------------------
package spsk_pkg;

    localparam int STEP_W     = 16;
    localparam int POS_W      = 12;
    localparam int REV_W      = 13;
    localparam int RPM_W      = 10;
    localparam int POT_W      = 12;
    localparam int TICK_W     = 26;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 2;
    localparam int COIL_W     = 4;
    localparam int PROD_W     = 23;
    localparam int SPEED_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;

    localparam int DIV_W      = 26;
    localparam int DIV_D_W    = 13;
    localparam int DIV_ITER   = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    localparam logic [TICK_W-1:0]  TICKS_PER_MINUTE = 26'd60000000;
    localparam logic [DIV_D_W-1:0] POT_FULL_SCALE   = 13'd4095;
    localparam logic [TICK_W-1:0]  TICK_SAT         = '1;
    localparam logic [REV_W-1:0]   REV_MAX          = 13'd4096;

    localparam logic [REV_W-1:0] RST_STEPS_PER_REV = 13'd200;
    localparam logic [RPM_W-1:0] RST_MIN_RPM       = 10'd1;
    localparam logic [RPM_W-1:0] RST_MAX_RPM       = 10'd60;
    localparam logic [RPM_W-1:0] RST_STOP_RPM      = 10'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RPM       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_RPM      = 2'd3;

    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [MODE_W-1:0] MODE_0 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_1 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_2 = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MAP_GO,
        S_MAP_WAIT,
        S_SPEED,
        S_REV_WAIT,
        S_SPD_WAIT,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [COIL_W-1:0] coil_for(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h5;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/spsk_div.sv
// ----------------------------------------------------------------------------
// spsk_div - shared iterative unsigned divider
// Restoring division, two quotient bits per cycle; a start loads the
// operands and done pulses in the cycle after the last pass.
// ----------------------------------------------------------------------------
module spsk_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spsk_pkg::t_div_req i_req,
    output spsk_pkg::t_div_rsp o_rsp
);
    import spsk_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_D_W-1:0]   r_dsr;

    logic [DIV_D_W:0]     w_try1;
    logic [DIV_D_W:0]     w_try2;
    logic                 w_q1;
    logic                 w_q2;
    logic [DIV_D_W-1:0]   w_rem1;
    logic [DIV_D_W-1:0]   w_rem2;
    logic [DIV_W-1:0]     n_quo;

    always_comb begin
        w_try1 = {r_rem, r_quo[DIV_W-1]};
        w_q1   = (w_try1 >= {1'b0, r_dsr});
        w_rem1 = w_q1 ? DIV_D_W'(w_try1 - {1'b0, r_dsr}) : w_try1[DIV_D_W-1:0];
        w_try2 = {w_rem1, r_quo[DIV_W-2]};
        w_q2   = (w_try2 >= {1'b0, r_dsr});
        w_rem2 = w_q2 ? DIV_D_W'(w_try2 - {1'b0, r_dsr}) : w_try2[DIV_D_W-1:0];
        n_quo  = {r_quo[DIV_W-3:0], w_q1, w_q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/stepper_phase_sequencer_speed_knob.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_speed_knob - four-coil full-step stepper sequencer
// Move requests load a signed step count; tick requests map the speed knob,
// derive the step delay with a shared divider and step the coils.
//
//   channel  dir  payload (lsb first)
//   s_axis   in   tuser: req_type; tdata: step_count, pot_sample,
//                 button_mode0_n, button_mode1_n, button_cycle_n
//   m_axis   out  tdata: coil_pattern, position, mode_now, press_count,
//                 steps_remaining, stepped, aborted
//   cfg      in   we / idx / wdata register writes
//
// A move request or a tick with no move loaded goes from S_LOAD to S_DONE.
// A tick during a move makes up to three passes of the shared divider (knob
// scaling, ticks per step, ticks per step at speed); an abort ends it early.
// Synchronous active-low reset clears the control state and loads register
// defaults, but not the data registers. The result register frees the input
// side; a stalled result holds only the final write-back of the next request.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_speed_knob (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // step_count[15:0], pot_sample[27:16], button_mode0_n[28],
    // button_mode1_n[29], button_cycle_n[30], zero[31]
    input  logic [spsk_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // req_type[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // coil_pattern[3:0], position[15:4], mode_now[17:16], press_count[19:18],
    // steps_remaining[35:20], stepped[36], aborted[37], zero[39:38]
    output logic [spsk_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [spsk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spsk_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import spsk_pkg::*;

    t_state r_state, n_state;

    logic [REV_W-1:0]  r_steps_per_rev;
    logic [RPM_W-1:0]  r_min_rpm;
    logic [RPM_W-1:0]  r_max_rpm;
    logic [RPM_W-1:0]  r_stop_rpm;

    logic              r_req, n_req;
    logic [STEP_W-1:0] r_step_cnt, n_step_cnt;
    logic [POT_W-1:0]  r_pot, n_pot;
    logic              r_btn0_n, n_btn0_n;
    logic              r_btn1_n, n_btn1_n;
    logic              r_btnc_n, n_btnc_n;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_fwd, n_fwd;
    logic [STEP_W-1:0] r_left, n_left;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [CNT_W-1:0]  r_press, n_press;
    logic              r_btn_now, n_btn_now;
    logic              r_btn_prev, n_btn_prev;
    logic [COIL_W-1:0] r_coil, n_coil;

    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [RPM_W-1:0]  r_speed, n_speed;
    logic              r_stepped, n_stepped;
    logic              r_aborted, n_aborted;

    logic                r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                       w_s_acc;
    logic                       w_out_free;
    logic [REV_W-1:0]           w_eff_n;
    logic signed [RPM_W:0]      w_span;
    logic signed [PROD_W-1:0]   w_prod_full;
    logic [PROD_W-1:0]          w_prod_mag;
    logic signed [SPEED_W-1:0]  w_map_q;
    logic signed [SPEED_W-1:0]  w_speed;
    logic                       w_abort;
    logic                       w_step_now;

    spsk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;
        w_out_free = !r_out_valid || i_m_axis_tready;
        if (r_steps_per_rev == '0) begin
            w_eff_n = REV_W'(1);
        end else if (r_steps_per_rev > REV_MAX) begin
            w_eff_n = REV_MAX;
        end else begin
            w_eff_n = r_steps_per_rev;
        end
        w_span      = $signed({1'b0, r_min_rpm}) - $signed({1'b0, r_max_rpm});
        w_prod_full = $signed({{(PROD_W-POT_W){1'b0}}, r_pot}) * PROD_W'(w_span);
        w_prod_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_map_q     = r_prod[PROD_W-1] ? -$signed(w_div_rsp.quotient[SPEED_W-1:0])
                                       : $signed(w_div_rsp.quotient[SPEED_W-1:0]);
        w_speed     = $signed({2'b00, r_max_rpm}) + w_map_q;
        w_abort     = (w_speed <= $signed({2'b00, r_stop_rpm}));
        w_step_now  = (r_ticks >= w_div_rsp.quotient);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_s_acc) n_state = S_LOAD;
            S_LOAD: begin
                if (r_req == REQ_TICK && r_left != '0) begin
                    n_state = S_MAP_GO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MAP_GO:   n_state = S_MAP_WAIT;
            S_MAP_WAIT: if (w_div_rsp.done) n_state = S_SPEED;
            S_SPEED:    n_state = w_abort ? S_DONE : S_REV_WAIT;
            S_REV_WAIT: if (w_div_rsp.done) n_state = S_SPD_WAIT;
            S_SPD_WAIT: if (w_div_rsp.done) n_state = S_DECIDE;
            S_DECIDE:   n_state = S_DONE;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [REV_W-1:0]  pos_inc;
        logic [POS_W-1:0]  pos_nx;
        logic [MODE_W-1:0] mode_nx;
        logic [CNT_W-1:0]  press_nx;

        o_s_axis_tready = (r_state == S_IDLE);
        w_div_req       = '0;

        n_req      = r_req;
        n_step_cnt = r_step_cnt;
        n_pot      = r_pot;
        n_btn0_n   = r_btn0_n;
        n_btn1_n   = r_btn1_n;
        n_btnc_n   = r_btnc_n;
        n_pos      = r_pos;
        n_fwd      = r_fwd;
        n_left     = r_left;
        n_ticks    = r_ticks;
        n_mode     = r_mode;
        n_press    = r_press;
        n_btn_now  = r_btn_now;
        n_btn_prev = r_btn_prev;
        n_coil     = r_coil;
        n_prod     = r_prod;
        n_speed    = r_speed;
        n_stepped  = r_stepped;
        n_aborted  = r_aborted;

        pos_inc  = {1'b0, r_pos} + 1'b1;
        pos_nx   = r_pos;
        mode_nx  = r_mode;
        press_nx = r_press;

        n_out_data  = {2'b00, r_aborted, r_stepped, r_left, r_press, r_mode, r_pos, r_coil};
        n_out_valid = r_out_valid && !i_m_axis_tready;

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_req      = i_s_axis_tuser;
                    n_step_cnt = i_s_axis_tdata[15:0];
                    n_pot      = i_s_axis_tdata[27:16];
                    n_btn0_n   = i_s_axis_tdata[28];
                    n_btn1_n   = i_s_axis_tdata[29];
                    n_btnc_n   = i_s_axis_tdata[30];
                    n_stepped  = 1'b0;
                    n_aborted  = 1'b0;
                end
            end
            S_LOAD: begin
                if (r_req == REQ_MOVE) begin
                    if (r_step_cnt == '0) begin
                        n_left = '0;
                    end else if (r_step_cnt[STEP_W-1]) begin
                        n_fwd  = 1'b0;
                        n_left = STEP_W'(-r_step_cnt);
                    end else begin
                        n_fwd  = 1'b1;
                        n_left = r_step_cnt;
                    end
                end else begin
                    if (r_ticks != TICK_SAT) n_ticks = r_ticks + 1'b1;
                    n_prod = w_prod_full[PROD_W-1:0];
                end
            end
            S_MAP_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIV_W'(w_prod_mag);
                w_div_req.divisor  = POT_FULL_SCALE;
            end
            S_SPEED: begin
                if (w_abort) begin
                    n_left    = '0;
                    n_aborted = 1'b1;
                end else begin
                    n_speed            = w_speed[RPM_W-1:0];
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = TICKS_PER_MINUTE;
                    w_div_req.divisor  = w_eff_n;
                end
            end
            S_REV_WAIT: begin
                if (w_div_rsp.done) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_div_rsp.quotient;
                    w_div_req.divisor  = DIV_D_W'(r_speed);
                end
            end
            S_DECIDE: begin
                if (w_step_now) begin
                    if (r_fwd) begin
                        pos_nx = (pos_inc >= w_eff_n) ? '0 : pos_inc[POS_W-1:0];
                    end else if (r_pos == '0 || {1'b0, r_pos} >= w_eff_n) begin
                        pos_nx = POS_W'(w_eff_n - 1'b1);
                    end else begin
                        pos_nx = r_pos - 1'b1;
                    end
                    if (!r_btn0_n) begin
                        mode_nx  = MODE_0;
                        press_nx = '0;
                    end
                    if (!r_btn1_n) begin
                        mode_nx  = MODE_1;
                        press_nx = '0;
                    end
                    if (r_btn_now && !r_btnc_n) begin
                        mode_nx  = MODE_2;
                        press_nx = press_nx + 1'b1;
                    end
                    n_pos      = pos_nx;
                    n_coil     = coil_for(pos_nx[1:0]);
                    n_left     = r_left - 1'b1;
                    n_ticks    = '0;
                    n_btn_prev = r_btn_now;
                    n_btn_now  = r_btnc_n;
                    n_mode     = mode_nx;
                    n_press    = press_nx;
                    n_stepped  = 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_steps_per_rev <= RST_STEPS_PER_REV;
            r_min_rpm       <= RST_MIN_RPM;
            r_max_rpm       <= RST_MAX_RPM;
            r_stop_rpm      <= RST_STOP_RPM;
            r_pos           <= '0;
            r_fwd           <= 1'b0;
            r_left          <= '0;
            r_ticks         <= '0;
            r_mode          <= MODE_0;
            r_press         <= '0;
            r_btn_now       <= 1'b0;
            r_btn_prev      <= 1'b0;
            r_coil          <= '0;
            r_stepped       <= 1'b0;
            r_aborted       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fwd       <= n_fwd;
            r_left      <= n_left;
            r_ticks     <= n_ticks;
            r_mode      <= n_mode;
            r_press     <= n_press;
            r_btn_now   <= n_btn_now;
            r_btn_prev  <= n_btn_prev;
            r_coil      <= n_coil;
            r_stepped   <= n_stepped;
            r_aborted   <= n_aborted;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEPS_PER_REV: r_steps_per_rev <= i_cfg_wdata;
                    CFG_MIN_RPM:       r_min_rpm       <= i_cfg_wdata[RPM_W-1:0];
                    CFG_MAX_RPM:       r_max_rpm       <= i_cfg_wdata[RPM_W-1:0];
                    CFG_STOP_RPM:      r_stop_rpm      <= i_cfg_wdata[RPM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_step_cnt <= n_step_cnt;
        r_pot      <= n_pot;
        r_btn0_n   <= n_btn0_n;
        r_btn1_n   <= n_btn1_n;
        r_btnc_n   <= n_btnc_n;
        r_prod     <= n_prod;
        r_speed    <= n_speed;
        if (r_state == S_DONE && w_out_free) r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div_rsp.busy)
        else $error("divider busy while taking a request");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_stepped && r_aborted))
        else $error("step and abort in one request");

    a_step_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_step_now) |=> (r_ticks == '0))
        else $error("tick count not cleared by step");

    a_step_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_step_now) |=> ({1'b0, r_pos} < w_eff_n))
        else $error("position outside revolution after step");

    a_speed_above_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REV_WAIT) |-> (r_speed > r_stop_rpm))
        else $error("delay divide with speed at or below stop bound");
`endif

endmodule
